// ----- src/crlf_pkg.sv -----
// shared constants and control types for the crlf response framer
`timescale 1ns / 1ps

package crlf_pkg;

	localparam int RESP_LEN = 64;
	localparam int IDX_W    = 6;

	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(RESP_LEN - 1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;

	// framing states
	localparam logic [2:0] FR_IDLE = 3'd0;
	localparam logic [2:0] FR_CR   = 3'd1;
	localparam logic [2:0] FR_OPEN = 3'd2;
	localparam logic [2:0] FR_TEXT = 3'd3;
	localparam logic [2:0] FR_CR2  = 3'd4;

	// sequencer states
	localparam logic [1:0] SQ_IN    = 2'd0;
	localparam logic [1:0] SQ_FETCH = 2'd1;
	localparam logic [1:0] SQ_PUSH  = 2'd2;

	typedef struct packed {
		logic store;
		logic clr_idx;
		logic start_run;
		logic fetch_next;
		logic push;
	} crlf_cmd_t;

	typedef struct packed {
		logic byte_nul;
		logic byte_cr;
		logic byte_lf;
		logic idx_zero;
		logic run_last;
		logic out_free;
	} crlf_status_t;

endpackage

// ----- src/crlf_response_framer_top.sv -----
// Finds CR LF text CR LF responses in a byte stream and emits each response
// one byte per output word, with its position, the response length and a last
// flag. Zero bytes are ignored. Text beyond 63 bytes is dropped, and bytes of
// an aborted frame are kept and emitted with the next complete frame. An input
// byte is taken every cycle while no response is being emitted. On the closing
// LF of a frame with stored text the input stalls and the stored response is
// sent out word by word, each word by a registered read of the response store
// followed by the load of the output register, and the input is held, also
// while the output stalls, until the last word is loaded. No clearing pass.
`timescale 1ns / 1ps

module crlf_response_framer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  resp_byte,
	output logic [crlf_pkg::IDX_W-1:0]  byte_index,
	output logic [crlf_pkg::IDX_W-1:0]  resp_length,
	output logic                        last
);

	crlf_pkg::crlf_cmd_t    cmd;
	crlf_pkg::crlf_status_t st;

	crlf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	crlf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.resp_byte   (resp_byte),
		.byte_index  (byte_index),
		.resp_length (resp_length),
		.last        (last)
	);

endmodule

// ----- src/crlf_dp.sv -----
// datapath: response store, index counters and output word register
`timescale 1ns / 1ps

module crlf_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_ready,
	input  crlf_pkg::crlf_cmd_t         cmd,
	output crlf_pkg::crlf_status_t      st,
	output logic                        out_valid,
	output logic [7:0]                  resp_byte,
	output logic [crlf_pkg::IDX_W-1:0]  byte_index,
	output logic [crlf_pkg::IDX_W-1:0]  resp_length,
	output logic                        last
);

	logic [7:0]                 mem [crlf_pkg::RESP_LEN];
	logic [7:0]                 rd_data_q;
	logic [crlf_pkg::IDX_W-1:0] char_idx_q;
	logic [crlf_pkg::IDX_W-1:0] rd_idx_q;
	logic [crlf_pkg::IDX_W-1:0] len_q;
	logic                       out_valid_q;
	logic [7:0]                 resp_byte_q;
	logic [crlf_pkg::IDX_W-1:0] byte_index_q;
	logic [crlf_pkg::IDX_W-1:0] resp_length_q;
	logic                       last_q;
	logic                       run_last;

	assign run_last = (rd_idx_q == (len_q - crlf_pkg::IDX_W'(1)));

	always_comb begin
		st.byte_nul = (rx_byte == crlf_pkg::CH_NUL);
		st.byte_cr  = (rx_byte == crlf_pkg::CH_CR);
		st.byte_lf  = (rx_byte == crlf_pkg::CH_LF);
		st.idx_zero = (char_idx_q == '0);
		st.run_last = run_last;
		st.out_free = !out_valid_q || out_ready;
	end

	// store write, registered read
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[char_idx_q] <= rx_byte;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_idx_q <= '0;
			rd_idx_q   <= '0;
			len_q      <= '0;
		end else begin
			// index saturates on the last slot
			if (cmd.clr_idx) begin
				char_idx_q <= '0;
			end else if (cmd.store && (char_idx_q < crlf_pkg::IDX_MAX)) begin
				char_idx_q <= char_idx_q + crlf_pkg::IDX_W'(1);
			end
			if (cmd.start_run) begin
				len_q    <= char_idx_q;
				rd_idx_q <= '0;
			end else if (cmd.fetch_next) begin
				rd_idx_q <= rd_idx_q + crlf_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			resp_byte_q   <= rd_data_q;
			byte_index_q  <= rd_idx_q;
			resp_length_q <= len_q;
			last_q        <= run_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign resp_byte   = resp_byte_q;
	assign byte_index  = byte_index_q;
	assign resp_length = resp_length_q;
	assign last        = last_q;

endmodule

// ----- src/crlf_ctrl.sv -----
// controller: framing state machine and emit sequencer
`timescale 1ns / 1ps

module crlf_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  crlf_pkg::crlf_status_t  st,
	output crlf_pkg::crlf_cmd_t     cmd
);

	logic [2:0] frame_q;
	logic [2:0] frame_d;
	logic [1:0] seq_q;
	logic [1:0] seq_d;

	assign in_ready = (seq_q == crlf_pkg::SQ_IN);

	always_comb begin
		frame_d = frame_q;
		seq_d   = seq_q;
		cmd     = '0;
		case (seq_q)
			crlf_pkg::SQ_IN: begin
				if (in_valid && !st.byte_nul) begin
					if (st.byte_cr) begin
						if (frame_q == crlf_pkg::FR_IDLE) begin
							frame_d = crlf_pkg::FR_CR;
						end else if (frame_q == crlf_pkg::FR_TEXT) begin
							frame_d = crlf_pkg::FR_CR2;
						end
					end else if (st.byte_lf) begin
						if (frame_q inside {crlf_pkg::FR_CR, crlf_pkg::FR_OPEN}) begin
							frame_d = crlf_pkg::FR_OPEN;
						end else if (frame_q == crlf_pkg::FR_CR2) begin
							// frame closed: emit stored text and restart the index
							frame_d     = crlf_pkg::FR_IDLE;
							cmd.clr_idx = 1'b1;
							if (!st.idx_zero) begin
								cmd.start_run = 1'b1;
								seq_d         = crlf_pkg::SQ_FETCH;
							end
						end else begin
							frame_d = crlf_pkg::FR_IDLE;
						end
					end else begin
						if (frame_q inside {crlf_pkg::FR_OPEN, crlf_pkg::FR_TEXT}) begin
							frame_d   = crlf_pkg::FR_TEXT;
							cmd.store = 1'b1;
						end else begin
							frame_d = crlf_pkg::FR_IDLE;
						end
					end
				end
			end
			crlf_pkg::SQ_FETCH: begin
				seq_d = crlf_pkg::SQ_PUSH;
			end
			crlf_pkg::SQ_PUSH: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					if (st.run_last) begin
						seq_d = crlf_pkg::SQ_IN;
					end else begin
						cmd.fetch_next = 1'b1;
						seq_d          = crlf_pkg::SQ_FETCH;
					end
				end
			end
			default: begin
				seq_d = crlf_pkg::SQ_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= crlf_pkg::FR_IDLE;
			seq_q   <= crlf_pkg::SQ_IN;
		end else begin
			frame_q <= frame_d;
			seq_q   <= seq_d;
		end
	end

	// a word is pushed only into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> st.out_free)
		else $error("push into occupied output register");

	// a run always begins with a store fetch
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_run |=> (seq_q == crlf_pkg::SQ_FETCH))
		else $error("run start did not fetch");

	// framer is idle for the whole emit run
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q != crlf_pkg::SQ_IN) |-> (frame_q == crlf_pkg::FR_IDLE))
		else $error("framer not idle during emit");

	// no text is stored while emitting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> (seq_q == crlf_pkg::SQ_IN) && in_valid)
		else $error("store outside input phase");

endmodule
